// ===== hw/rtl/cmfa_pkg.sv =====
package cmfa_pkg;

    localparam int NUM_CELLS = 32;
    localparam int IDX_W     = $clog2(NUM_CELLS);
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);

    localparam int OP_W      = 3;
    localparam int TAG_W     = 8;
    localparam int SIZE_W    = 6;
    localparam int CIDX_W    = 5;
    localparam int STAT_W    = 2;
    localparam int START_W   = 5;
    localparam int FREE_W    = 6;

    // Common width for mixed compares and sums of indexes, counts and sizes.
    localparam int CMP_W     = (CNT_W + 1 > SIZE_W + 1) ? CNT_W + 1 : SIZE_W + 1;

    localparam logic [TAG_W-1:0] FREE_TAG = 8'h20;

    localparam logic [OP_W-1:0] OP_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_BEST  = 3'd1;
    localparam logic [OP_W-1:0] OP_WORST = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             idle;
        logic             decide;
        logic             scan_rd;
        logic             close;
        logic             check;
        logic             fill;
        logic             wr_rd;
        logic             wr;
        logic             out_load;
        logic [IDX_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic in_fire;
        logic is_write;
        logic early_done;
        logic scan_ok;
        logic fill_last;
        logic out_full;
    } t_dp_stat;

endpackage

// ===== hw/rtl/cmfa_in_if.sv =====
interface cmfa_in_if import cmfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] run_size;
    logic [CIDX_W-1:0] cell_index;

    modport source (output valid, op, tag, run_size, cell_index, input ready);
    modport sink   (input valid, op, tag, run_size, cell_index, output ready);
endinterface

// ===== hw/rtl/cmfa_out_if.sv =====
interface cmfa_out_if import cmfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [START_W-1:0] start_index;
    logic [FREE_W-1:0]  free_cells;

    modport source (output valid, status, start_index, free_cells, input ready);
    modport sink   (input valid, status, start_index, free_cells, output ready);
endinterface

// ===== hw/rtl/cmfa_ctrl.sv =====
module cmfa_ctrl import cmfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_st,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_CLOSE  = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_FILL   = 4'd6;
    localparam logic [3:0] S_WR_RD  = 4'd7;
    localparam logic [3:0] S_WR     = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CELLS - 1);

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_st.in_fire) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_cnt = '0;
                if (i_st.early_done) begin
                    n_state = S_RESP;
                end else if (i_st.is_write) begin
                    n_state = S_WR_RD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt = '0;
                n_state = i_st.scan_ok ? S_FILL : S_RESP;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_st.fill_last) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WR_RD: begin
                o_cmd.wr_rd = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_st.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_st.out_full)
        else $error("result loaded while the output slot is still held");

    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_st.fill_last) |=> r_state == S_RESP)
        else $error("fill did not end at its last cell");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.in_fire |-> r_state == S_IDLE)
        else $error("item accepted outside idle");
`endif

endmodule

// ===== hw/rtl/cmfa_dp.sv =====
module cmfa_dp import cmfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_st,
    cmfa_in_if.sink           i_in,
    cmfa_out_if.source        o_out
);

    // Cell map and per-cell written flags; an unwritten cell reads as free.
    logic [TAG_W-1:0]     r_mem [NUM_CELLS];
    logic [NUM_CELLS-1:0] r_init;
    logic [TAG_W-1:0]     r_rd_data;
    logic                 r_rd_init;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;

    // Captured item.
    logic [OP_W-1:0]      r_op;
    logic [TAG_W-1:0]     r_tag;
    logic [SIZE_W-1:0]    r_size;
    logic [CIDX_W-1:0]    r_cell_index;

    logic [CNT_W-1:0]     r_free_cnt;

    // Run search state.
    logic [IDX_W-1:0]     r_run_start;
    logic [CNT_W-1:0]     r_run_len;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_start;
    logic [CNT_W-1:0]     r_best_slack;

    // Tag search state.
    logic [CNT_W-1:0]     r_hits;
    logic [IDX_W-1:0]     r_first;
    logic [CNT_W-1:0]     r_nonfree;

    logic [STAT_W-1:0]    r_status;
    logic [IDX_W-1:0]     r_start;

    logic                 r_out_vld;
    logic [STAT_W-1:0]    r_out_status;
    logic [START_W-1:0]   r_out_start;
    logic [FREE_W-1:0]    r_out_free;

    logic                 in_fire;
    logic                 is_alloc;
    logic                 is_free_op;
    logic                 is_write;
    logic                 size_zero;
    logic                 no_space;
    logic                 idx_ok;
    logic [TAG_W-1:0]     data_eff;
    logic                 data_free;
    logic                 step;
    logic                 cur_free;
    logic                 cur_hit;
    logic                 in_range;
    logic [IDX_W-1:0]     off;
    logic [CMP_W-1:0]     slack_w;
    logic                 take;
    logic [IDX_W-1:0]     fill_base;
    logic [CMP_W-1:0]     fill_addr_w;
    logic [IDX_W-1:0]     cell_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_addr;
    logic [TAG_W-1:0]     wr_data;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = i_cmd.idle;

    assign is_alloc   = (r_op <= OP_WORST);
    assign is_free_op = (r_op == OP_FREE);
    assign is_write   = (r_op == OP_WRITE);
    assign size_zero  = (r_size == '0);
    assign no_space   = CMP_W'(r_size) > CMP_W'(r_free_cnt);
    assign idx_ok     = CMP_W'(r_cell_index) < CMP_W'(NUM_CELLS);
    assign cell_addr  = IDX_W'(r_cell_index);

    assign data_eff   = r_rd_init ? r_rd_data : FREE_TAG;
    assign data_free  = (data_eff == FREE_TAG);
    assign step       = r_rd_vld || i_cmd.close;
    assign cur_free   = r_rd_vld && data_free;
    assign cur_hit    = r_rd_vld && (data_eff == r_tag);
    assign off        = r_rd_idx - r_first;
    assign in_range   = (r_hits != '0) ? (CMP_W'(off) < CMP_W'(r_size)) : cur_hit;
    assign slack_w    = CMP_W'(r_run_len) - CMP_W'(r_size);

    always_comb begin
        take = 1'b0;
        if (!r_found) begin
            take = 1'b1;
        end else if (r_op == OP_BEST && CNT_W'(slack_w) < r_best_slack) begin
            take = 1'b1;
        end else if (r_op == OP_WORST && CNT_W'(slack_w) > r_best_slack) begin
            take = 1'b1;
        end
    end

    assign fill_base   = is_alloc ? r_best_start : r_first;
    assign fill_addr_w = CMP_W'(fill_base) + CMP_W'(i_cmd.cnt);

    assign o_st.in_fire    = in_fire;
    assign o_st.is_write   = is_write;
    assign o_st.early_done = ((is_alloc || is_free_op) && size_zero)
                          || (is_alloc && no_space)
                          || (!is_alloc && !is_free_op && !(is_write && idx_ok));
    assign o_st.scan_ok    = is_alloc ? r_found : (CMP_W'(r_hits) >= CMP_W'(r_size));
    assign o_st.fill_last  = (CMP_W'(i_cmd.cnt) + 1'b1 == CMP_W'(r_size))
                          || (fill_addr_w + 1'b1 == CMP_W'(NUM_CELLS));
    assign o_st.out_full   = r_out_vld && !o_out.ready;

    assign rd_addr = i_cmd.wr_rd ? cell_addr : i_cmd.cnt;
    assign mem_we  = i_cmd.fill || i_cmd.wr;
    assign wr_addr = i_cmd.fill ? IDX_W'(fill_addr_w) : cell_addr;
    assign wr_data = (i_cmd.fill && is_free_op) ? FREE_TAG : r_tag;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_init <= r_init[rd_addr];
        r_rd_idx  <= i_cmd.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (mem_we) begin
                r_init[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op         <= i_in.op;
            r_tag        <= i_in.tag;
            r_size       <= i_in.run_size;
            r_cell_index <= i_in.cell_index;
        end
    end

    // Search registers, cleared when an item comes in.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_found      <= 1'b0;
            r_best_start <= '0;
            r_best_slack <= '0;
            r_hits       <= '0;
            r_first      <= '0;
            r_nonfree    <= '0;
        end else if (step) begin
            if (cur_free) begin
                if (r_run_len == '0) begin
                    r_run_start <= r_rd_idx;
                end
                r_run_len <= r_run_len + 1'b1;
            end else begin
                // A used cell or the end of the map closes the current run.
                if (r_run_len != '0 && CMP_W'(r_run_len) >= CMP_W'(r_size) && take) begin
                    r_found      <= 1'b1;
                    r_best_start <= r_run_start;
                    r_best_slack <= CNT_W'(slack_w);
                end
                r_run_len <= '0;
            end
            if (cur_hit) begin
                if (r_hits == '0) begin
                    r_first <= r_rd_idx;
                end
                r_hits <= r_hits + 1'b1;
            end
            if (r_rd_vld && in_range && !data_free) begin
                r_nonfree <= r_nonfree + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= CNT_W'(NUM_CELLS);
        end else if (i_cmd.check && o_st.scan_ok) begin
            if (is_alloc) begin
                if (r_tag != FREE_TAG) begin
                    r_free_cnt <= r_free_cnt - CNT_W'(r_size);
                end
            end else begin
                r_free_cnt <= r_free_cnt + r_nonfree;
            end
        end else if (i_cmd.wr) begin
            if (data_free && r_tag != FREE_TAG) begin
                r_free_cnt <= r_free_cnt - 1'b1;
            end else if (!data_free && r_tag == FREE_TAG) begin
                r_free_cnt <= r_free_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= ST_OK;
            r_start  <= '0;
        end else if (i_cmd.decide) begin
            if ((is_alloc || is_free_op) && size_zero) begin
                r_status <= ST_NO_FIT;
            end else if (is_alloc && no_space) begin
                r_status <= ST_NO_SPACE;
            end
        end else if (i_cmd.check) begin
            if (o_st.scan_ok) begin
                r_start <= fill_base;
            end else begin
                r_status <= is_alloc ? ST_NO_FIT : ST_NOT_FOUND;
            end
        end else if (i_cmd.wr) begin
            r_start <= cell_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_start  <= START_W'(r_start);
            r_out_free   <= FREE_W'(r_free_cnt);
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out_status;
    assign o_out.start_index = r_out_start;
    assign o_out.free_cells  = r_out_free;

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_free_cnt) <= CMP_W'(NUM_CELLS))
        else $error("free cell count exceeds the map size");

    a_fill_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> fill_addr_w < CMP_W'(NUM_CELLS))
        else $error("fill address beyond the last cell");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_out_status)
            && $stable(r_out_start) && $stable(r_out_free)))
        else $error("result item changed while waiting to be taken");
`endif

endmodule

// ===== hw/rtl/cell_map_fit_allocator.sv =====
// Contiguous-run cell allocator over a 32-cell tag map held in a memory that
// reads as all free after reset. An alloc or free item reads the whole map
// once, one cell per cycle, and then writes its run one cell per cycle. A
// failed search writes nothing. A write-cell item reads the addressed cell
// and then writes it. An unused op code, or an item rejected on its size or
// on the free total, skips the map and goes straight to its result. A new
// item is accepted in the cycle after the result is loaded. Items are
// processed one at a time. A new item is taken once the previous result
// sits in the output register, even if the sink has not yet taken it. A
// sink that stalls while that register is still full holds the block until
// it frees up.
module cell_map_fit_allocator import cmfa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmfa_in_if.sink    i_in,
    cmfa_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat st;

    cmfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    cmfa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_st    (st),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== test/cell_map_fit_allocator_tb.sv =====
module cell_map_fit_allocator_tb;
    import cmfa_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS   = 1880;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_ROWS  = 23;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [START_W-1:0] start_index;
        logic [FREE_W-1:0]  free_cells;
    } t_alloc_result;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] run_size;
        logic [CIDX_W-1:0] cell_index;
        bit                fixed;
        t_alloc_result     want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    cmfa_in_if  alloc_req ();
    cmfa_out_if alloc_rsp ();

    cell_map_fit_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (alloc_req),
        .o_out   (alloc_rsp)
    );

    // Shadow copy of the tag map, advanced on every accepted item.
    logic [TAG_W-1:0] cell_map [NUM_CELLS];
    t_alloc_result    pending_results [$];
    int               mismatches;
    int               burst_left;
    bit               timed_out;

    logic [TAG_W-1:0] tag_pool [6] = '{8'h01, 8'h5A, 8'hA5, 8'hFE, 8'h7F, 8'h80};

    // Rows with a fixed result can be read straight off the empty or full map.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_FIRST,    8'h41,    6'd0,  5'd0,  1'b1, '{ST_NO_FIT,    5'd0,  6'd32}},
        '{OP_FREE,     8'h41,    6'd0,  5'd0,  1'b1, '{ST_NO_FIT,    5'd0,  6'd32}},
        '{OP_BEST,     8'h41,    6'd33, 5'd0,  1'b1, '{ST_NO_SPACE,  5'd0,  6'd32}},
        '{OP_WORST,    8'h41,    6'd63, 5'd0,  1'b1, '{ST_NO_SPACE,  5'd0,  6'd32}},
        '{OP_FREE,     8'h41,    6'd1,  5'd0,  1'b1, '{ST_NOT_FOUND, 5'd0,  6'd32}},
        '{OP_FIRST,    8'hFF,    6'd32, 5'd0,  1'b1, '{ST_OK,        5'd0,  6'd0}},
        '{OP_BEST,     8'h01,    6'd1,  5'd0,  1'b1, '{ST_NO_SPACE,  5'd0,  6'd0}},
        '{OP_FREE,     8'hFF,    6'd33, 5'd0,  1'b1, '{ST_NOT_FOUND, 5'd0,  6'd0}},
        '{OP_FREE,     8'hFF,    6'd32, 5'd0,  1'b1, '{ST_OK,        5'd0,  6'd32}},
        '{OP_WRITE,    8'h00,    6'd0,  5'd31, 1'b1, '{ST_OK,        5'd31, 6'd31}},
        '{OP_WRITE,    8'hAA,    6'd63, 5'd10, 1'b0, '0},
        '{OP_BEST,     8'h11,    6'd3,  5'd0,  1'b0, '0},
        '{OP_WORST,    8'h22,    6'd3,  5'd0,  1'b0, '0},
        '{OP_FIRST,    8'h33,    6'd20, 5'd0,  1'b0, '0},
        '{OP_WRITE,    FREE_TAG, 6'd0,  5'd31, 1'b0, '0},
        '{OP_FIRST,    8'h33,    6'd18, 5'd0,  1'b0, '0},
        '{OP_FREE,     8'h11,    6'd4,  5'd0,  1'b0, '0},
        '{OP_FREE,     8'h22,    6'd2,  5'd0,  1'b0, '0},
        '{OP_FIRST,    FREE_TAG, 6'd2,  5'd0,  1'b0, '0},
        '{OP_FREE,     FREE_TAG, 6'd5,  5'd0,  1'b0, '0},
        '{OP_SPARE_LO, 8'hFF,    6'd63, 5'd31, 1'b0, '0},
        '{OP_SPARE_HI, 8'h00,    6'd1,  5'd0,  1'b0, '0},
        '{OP_WRITE,    8'h55,    6'd0,  5'd0,  1'b0, '0}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int count_tag(logic [TAG_W-1:0] tag);
        int n;
        n = 0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (cell_map[i] == tag) n++;
        end
        return n;
    endfunction

    function automatic t_alloc_result apply_alloc_op(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                                                     logic [SIZE_W-1:0] run_size,
                                                     logic [CIDX_W-1:0] cell_index);
        t_alloc_result res;
        int  size;
        int  start;
        int  run_start;
        int  run_len;
        int  slack;
        int  pick_slack;
        int  hits;
        int  first;
        bit  found;
        bit  take;
        bit  is_free;
        res   = '0;
        res.status = ST_OK;
        size  = int'(run_size);
        start = 0;
        if (op == OP_FIRST || op == OP_BEST || op == OP_WORST) begin
            if (size == 0) begin
                res.status = ST_NO_FIT;
            end else if (count_tag(FREE_TAG) < size) begin
                res.status = ST_NO_SPACE;
            end else begin
                found = 1'b0;
                run_start = 0;
                run_len = 0;
                pick_slack = 0;
                // One position past the map closes a run that reaches the last cell.
                for (int i = 0; i <= NUM_CELLS; i++) begin
                    is_free = (i < NUM_CELLS) && (cell_map[i] == FREE_TAG);
                    if (is_free) begin
                        if (run_len == 0) run_start = i;
                        run_len++;
                    end else begin
                        if (run_len >= size) begin
                            slack = run_len - size;
                            take = !found
                                || (op == OP_BEST && slack < pick_slack)
                                || (op == OP_WORST && slack > pick_slack);
                            if (take) begin
                                found = 1'b1;
                                start = run_start;
                                pick_slack = slack;
                                if (op == OP_FIRST) break;
                            end
                        end
                        run_len = 0;
                    end
                end
                if (!found) begin
                    res.status = ST_NO_FIT;
                    start = 0;
                end else begin
                    for (int i = 0; i < size && start + i < NUM_CELLS; i++)
                        cell_map[start + i] = tag;
                end
            end
        end else if (op == OP_FREE) begin
            if (size == 0) begin
                res.status = ST_NO_FIT;
            end else begin
                hits = 0;
                first = 0;
                for (int i = 0; i < NUM_CELLS; i++) begin
                    if (cell_map[i] == tag) begin
                        if (hits == 0) first = i;
                        hits++;
                    end
                end
                if (hits < size) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    start = first;
                    for (int i = 0; i < size && first + i < NUM_CELLS; i++)
                        cell_map[first + i] = FREE_TAG;
                end
            end
        end else if (op == OP_WRITE) begin
            if (int'(cell_index) < NUM_CELLS) begin
                cell_map[cell_index] = tag;
                start = int'(cell_index);
            end
        end
        res.start_index = START_W'(start);
        res.free_cells  = FREE_W'(count_tag(FREE_TAG));
        return res;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 9) == 0) return TAG_W'($urandom_range(0, 255));
        return tag_pool[$urandom_range(0, 5)];
    endfunction

    task automatic send_item(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                             logic [SIZE_W-1:0] run_size, logic [CIDX_W-1:0] cell_index,
                             bit fixed, t_alloc_result want);
        int            gap;
        t_alloc_result predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                alloc_req.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        alloc_req.valid      = 1'b1;
        alloc_req.op         = op;
        alloc_req.tag        = tag;
        alloc_req.run_size   = run_size;
        alloc_req.cell_index = cell_index;
        do @(posedge i_clk); while (!alloc_req.ready);
        predicted = apply_alloc_op(op, tag, run_size, cell_index);
        pending_results.push_back(fixed ? want : predicted);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] run_size;
        logic [CIDX_W-1:0] cell_index;
        int                pick;
        int                hits;
        pick       = $urandom_range(0, 99);
        tag        = pick_tag();
        cell_index = CIDX_W'($urandom_range(0, 31));
        if (pick < 45) begin
            op = OP_W'($urandom_range(0, 2));
            pick = $urandom_range(0, 19);
            if (pick < 16)      run_size = SIZE_W'($urandom_range(1, 6));
            else if (pick < 19) run_size = SIZE_W'($urandom_range(7, 32));
            else                run_size = SIZE_W'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
        end else if (pick < 80) begin
            op = OP_FREE;
            hits = count_tag(tag);
            pick = $urandom_range(0, 19);
            if (hits > 0 && pick < 10) run_size = SIZE_W'(hits);
            else if (pick < 18)        run_size = SIZE_W'($urandom_range(1, 4));
            else                       run_size = SIZE_W'($urandom_range(0, 63));
        end else if (pick < 92) begin
            op = OP_WRITE;
            run_size = SIZE_W'($urandom_range(0, 63));
        end else begin
            // Unused codes and fully random items.
            op = $urandom_range(0, 1) ? OP_W'($urandom_range(5, 7)) : OP_W'($urandom_range(0, 7));
            tag = TAG_W'($urandom_range(0, 255));
            run_size = SIZE_W'($urandom_range(0, 63));
        end
        send_item(op, tag, run_size, cell_index, 1'b0, '0);
    endtask

    task automatic report_mismatch(string why, t_alloc_result want, t_alloc_result got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s: expected status %0d start %0d free %0d, got status %0d start %0d free %0d",
                     why, want.status, want.start_index, want.free_cells,
                     got.status, got.start_index, got.free_cells);
    endtask

    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (i_rst_n && alloc_rsp.valid && alloc_rsp.ready) begin
            got.status      = alloc_rsp.status;
            got.start_index = alloc_rsp.start_index;
            got.free_cells  = alloc_rsp.free_cells;
            if (pending_results.size() == 0) begin
                report_mismatch("result item with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.start_index !== want.start_index
                        || got.free_cells !== want.free_cells)
                    report_mismatch("result item mismatch", want, got);
            end
        end
    end

    // The sink stalls on a rotating pattern that is replaced when its age counter runs out.
    initial begin
        logic [15:0] ready_pat;
        int          pat_age;
        alloc_rsp.ready = 1'b0;
        ready_pat = '1;
        pat_age = 0;
        forever begin
            @(negedge i_clk);
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pat = '1;
                    1: ready_pat = 16'($urandom);
                    2: ready_pat = 16'($urandom) | 16'($urandom);
                    default: ready_pat = 16'h0001 << $urandom_range(0, 15);
                endcase
                pat_age = 64;
            end
            ready_pat = {ready_pat[14:0], ready_pat[15]};
            alloc_rsp.ready = ready_pat[0];
            pat_age--;
        end
    end

    initial begin
        int idle_cycles;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        alloc_req.valid      = 1'b0;
        alloc_req.op         = OP_FIRST;
        alloc_req.tag        = '0;
        alloc_req.run_size   = '0;
        alloc_req.cell_index = '0;
        mismatches  = 0;
        burst_left  = 0;
        timed_out   = 1'b0;
        for (int i = 0; i < NUM_CELLS; i++) cell_map[i] = FREE_TAG;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            begin
                foreach (directed_rows[r])
                    send_item(directed_rows[r].op, directed_rows[r].tag,
                              directed_rows[r].run_size, directed_rows[r].cell_index,
                              directed_rows[r].fixed, directed_rows[r].want);
                repeat (RANDOM_ITEMS) send_random_item();
                alloc_req.valid = 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            begin
                idle_cycles = 0;
                while (idle_cycles < STALL_LIMIT) begin
                    @(posedge i_clk);
                    if ((alloc_req.valid && alloc_req.ready) || (alloc_rsp.valid && alloc_rsp.ready))
                        idle_cycles = 0;
                    else
                        idle_cycles++;
                end
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (!timed_out && mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
